>>> rtl/core/mdb_nine_bit_edge_receiver_macros.svh
// Assertion macros shared by the nine-bit edge receiver RTL.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef MDB_NINE_BIT_EDGE_RECEIVER_MACROS_SVH
`define MDB_NINE_BIT_EDGE_RECEIVER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MDBR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MDBR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/mdbr_pkg.sv
// Package for the nine-bit edge receiver: word types, register indices and
// queue sizing. No dependencies.
`default_nettype none

package mdbr_pkg;

  localparam int EDGE_QUEUE_DEPTH = 4;
  localparam int QUEUE_CNT_W      = $clog2(EDGE_QUEUE_DEPTH + 1);
  localparam int QUEUE_IDX_W      = (EDGE_QUEUE_DEPTH > 1) ? $clog2(EDGE_QUEUE_DEPTH) : 1;
  localparam logic [QUEUE_CNT_W-1:0] QUEUE_FULL_COUNT = QUEUE_CNT_W'(EDGE_QUEUE_DEPTH);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_TIME   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_MARGIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_WINDOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WINDOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT        = 3'd4;

  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [3:0] PHASE_IDLE      = 4'd0;
  localparam logic [3:0] PHASE_FIRST     = 4'd1;
  localparam logic [3:0] PHASE_LAST_DATA = 4'd8;
  localparam logic [3:0] PHASE_MODE      = 4'd9;
  localparam logic [3:0] PHASE_STOP      = 4'd10;

  typedef struct packed {
    logic        command;
    logic [31:0] event_time;
    logic        line_level;
  } in_word_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       mode_bit;
  } out_word_t;

  typedef struct packed {
    logic [15:0] symbol_time;
    logic [15:0] settle_margin;
    logic [15:0] data_window;
    logic [15:0] frame_window;
    logic        invert_polarity;
  } cfg_regs_t;

  typedef struct packed {
    logic        push;
    logic [31:0] push_time;
    logic        push_level;
    logic        pop;
  } queue_ctrl_t;

  typedef struct packed {
    logic        not_empty;
    logic [31:0] head_time;
    logic        head_level;
  } queue_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/mdbr_cfg_regs.sv
// Configuration register bank of the nine-bit edge receiver.
// Depends on mdbr_pkg.
`default_nettype none

module mdbr_cfg_regs
  import mdbr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_regs_t                  cfg
);

  cfg_regs_t cfg_r;
  cfg_regs_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SYMBOL_TIME:   cfg_nxt.symbol_time     = cfg_data;
        CFG_SETTLE_MARGIN: cfg_nxt.settle_margin   = cfg_data;
        CFG_DATA_WINDOW:   cfg_nxt.data_window     = cfg_data;
        CFG_FRAME_WINDOW:  cfg_nxt.frame_window    = cfg_data;
        CFG_INVERT:        cfg_nxt.invert_polarity = cfg_data[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.symbol_time     <= 16'd104;
      cfg_r.settle_margin   <= 16'd10;
      cfg_r.data_window     <= 16'd3;
      cfg_r.frame_window    <= 16'd5;
      cfg_r.invert_polarity <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> rtl/core/mdbr_edge_queue.sv
// Shift queue of timestamped line edges; the head entry is always at slot zero.
// Depends on mdbr_pkg and the receiver assertion macros.
`default_nettype none

`include "mdb_nine_bit_edge_receiver_macros.svh"

module mdbr_edge_queue
  import mdbr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire queue_ctrl_t ctrl,
  output queue_stat_t      stat
);

  logic [QUEUE_CNT_W-1:0] count_r;
  logic [QUEUE_CNT_W-1:0] count_nxt;
  logic [31:0]            time_r  [EDGE_QUEUE_DEPTH];
  logic                   level_r [EDGE_QUEUE_DEPTH];
  logic                   do_push;
  logic                   do_pop;

  assign do_push = ctrl.push && (count_r < QUEUE_FULL_COUNT);
  assign do_pop  = ctrl.pop && (count_r != '0);

  always_comb begin
    count_nxt = count_r;
    if (do_push) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      time_r[count_r[QUEUE_IDX_W-1:0]]  <= ctrl.push_time;
      level_r[count_r[QUEUE_IDX_W-1:0]] <= ctrl.push_level;
    end else if (do_pop) begin
      for (int i = 0; i < EDGE_QUEUE_DEPTH - 1; i++) begin
        time_r[i]  <= time_r[i+1];
        level_r[i] <= level_r[i+1];
      end
    end
  end

  assign stat.not_empty  = (count_r != '0);
  assign stat.head_time  = time_r[0];
  assign stat.head_level = level_r[0];

  `MDBR_ASSERT_NOW(a_count_bound, 1'b1, count_r <= QUEUE_FULL_COUNT, "edge queue overfilled")
  `MDBR_ASSERT_NOW(a_pop_not_empty, ctrl.pop, count_r != '0, "pop from empty edge queue")

endmodule

`default_nettype wire

>>> rtl/core/mdbr_frame_step.sv
// Frame state machine: one step per tick word, sampling bits against the
// edge queue head. Depends on mdbr_pkg and the receiver assertion macros.
`default_nettype none

`include "mdb_nine_bit_edge_receiver_macros.svh"

module mdbr_frame_step
  import mdbr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step_en,
  input  wire logic [31:0] tick_time,
  input  wire cfg_regs_t   cfg,
  input  wire queue_stat_t qstat,
  output logic             pop,
  output logic             done,
  output out_word_t        result
);

  logic [3:0]  bit_phase_r;
  logic [3:0]  bit_phase_nxt;
  logic [31:0] start_time_r;
  logic [31:0] start_time_nxt;
  logic        held_level_r;
  logic        held_level_nxt;
  logic [7:0]  data_shift_r;
  logic [7:0]  data_shift_nxt;
  logic        mode_held_r;
  logic        mode_held_nxt;

  logic        idle_like;
  logic [19:0] expected;
  logic [20:0] decide_limit;
  logic [31:0] elapsed;
  logic        late;
  logic [15:0] win;
  logic [31:0] head_delta;
  logic        above_low;
  logic        below_high;
  logic [20:0] high_edge;
  logic        take;
  logic        level_now;
  logic [2:0]  bit_pos;

  assign idle_like    = (bit_phase_r == PHASE_IDLE) || (bit_phase_r > PHASE_STOP);
  assign expected     = {16'd0, bit_phase_r} * {4'd0, cfg.symbol_time};
  assign decide_limit = {1'b0, expected} + {5'd0, cfg.settle_margin};
  assign elapsed      = tick_time - start_time_r;
  assign late         = elapsed > {11'd0, decide_limit};
  assign win          = (bit_phase_r <= PHASE_LAST_DATA) ? cfg.data_window : cfg.frame_window;
  assign head_delta   = qstat.head_time - start_time_r;
  assign above_low    = ({1'b0, head_delta} + {17'd0, win}) > {13'd0, expected};
  assign high_edge    = {1'b0, expected} + {5'd0, win};
  assign below_high   = head_delta < {11'd0, high_edge};
  assign take         = qstat.not_empty && above_low && below_high;
  assign level_now    = (take && (bit_phase_r <= PHASE_MODE)) ? qstat.head_level : held_level_r;
  assign bit_pos      = 3'(bit_phase_r - 4'd1);

  always_comb begin
    bit_phase_nxt   = bit_phase_r;
    start_time_nxt  = start_time_r;
    held_level_nxt  = held_level_r;
    data_shift_nxt  = data_shift_r;
    mode_held_nxt   = mode_held_r;
    pop             = 1'b0;
    done            = 1'b0;
    result.rx_byte  = data_shift_r ^ {8{cfg.invert_polarity}};
    result.mode_bit = mode_held_r ^ cfg.invert_polarity;
    if (step_en) begin
      if (idle_like) begin
        bit_phase_nxt = PHASE_IDLE;
        if (qstat.not_empty) begin
          start_time_nxt = qstat.head_time;
          held_level_nxt = qstat.head_level;
          data_shift_nxt = '0;
          mode_held_nxt  = 1'b0;
          bit_phase_nxt  = PHASE_FIRST;
          pop            = 1'b1;
        end
      end else if (late) begin
        pop            = take;
        held_level_nxt = level_now;
        if (bit_phase_r <= PHASE_LAST_DATA) begin
          data_shift_nxt          = data_shift_r;
          data_shift_nxt[bit_pos] = data_shift_r[bit_pos] | level_now;
          bit_phase_nxt           = bit_phase_r + 4'd1;
        end else if (bit_phase_r == PHASE_MODE) begin
          mode_held_nxt = level_now;
          bit_phase_nxt = PHASE_STOP;
        end else begin
          done          = 1'b1;
          bit_phase_nxt = PHASE_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_phase_r  <= PHASE_IDLE;
      start_time_r <= '0;
      held_level_r <= 1'b0;
      data_shift_r <= '0;
      mode_held_r  <= 1'b0;
    end else begin
      bit_phase_r  <= bit_phase_nxt;
      start_time_r <= start_time_nxt;
      held_level_r <= held_level_nxt;
      data_shift_r <= data_shift_nxt;
      mode_held_r  <= mode_held_nxt;
    end
  end

  `MDBR_ASSERT_NEXT(a_done_to_idle, done, bit_phase_r == PHASE_IDLE, "frame end did not return to idle")

endmodule

`default_nettype wire

>>> rtl/core/mdb_nine_bit_edge_receiver.sv
// Nine-bit MDB frame receiver working from timestamped line edges.
// Input channel (in_valid, in_stall, in_data) carries edge and tick words;
// each word is either an edge (command 0), queued for sampling unless the queue is full,
// or a time tick (command 1) that advances the frame machine by at most one step.
// Result channel (out_valid, out_stall, out_data) carries one word per
// completed frame: the data byte and the mode bit, inverted if so configured.
// Configuration port (cfg_we, cfg_index, cfg_data) writes the five timing
// and polarity registers; write only while no word is in flight.
// A word is registered on entry and processed once no result is held by out_stall;
// a frame's stop-phase tick passes the entry register, then its result the output register.
// Throughput: one word per cycle while out_stall holds no result.
// Reset (rst_n low, synchronous) empties the edge queue, returns the frame
// machine to idle and loads the default register values.
// While out_stall holds a result, the word in the entry register waits and
// in_stall is raised once that register is occupied.
// Depends on mdbr_pkg, mdbr_cfg_regs, mdbr_edge_queue and mdbr_frame_step.
`default_nettype none

`include "mdb_nine_bit_edge_receiver_macros.svh"

module mdb_nine_bit_edge_receiver
  import mdbr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_word_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_word_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic        in_valid_r;
  logic        in_valid_nxt;
  in_word_t    in_word_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  out_word_t   out_word_r;
  logic        proc_go;
  logic        proc_fire;
  logic        in_take;
  logic        step_en;
  logic        pop;
  logic        done;
  out_word_t   result;
  cfg_regs_t   cfg;
  queue_ctrl_t q_ctrl;
  queue_stat_t q_stat;

  assign proc_go   = !out_valid_r || !out_stall;
  assign proc_fire = in_valid_r && proc_go;
  assign in_stall  = in_valid_r && !proc_go;
  assign in_take   = in_valid && !in_stall;
  assign step_en   = proc_fire && (in_word_r.command == CMD_TICK);

  assign q_ctrl.push       = proc_fire && (in_word_r.command == CMD_EDGE);
  assign q_ctrl.push_time  = in_word_r.event_time;
  assign q_ctrl.push_level = in_word_r.line_level;
  assign q_ctrl.pop        = pop;

  mdbr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mdbr_edge_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (q_ctrl),
    .stat  (q_stat)
  );

  mdbr_frame_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .tick_time (in_word_r.event_time),
    .cfg       (cfg),
    .qstat     (q_stat),
    .pop       (pop),
    .done      (done),
    .result    (result)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (proc_fire) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (proc_fire && done) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_word_r <= in_data;
    end
    if (proc_fire && done) begin
      out_word_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  `MDBR_ASSERT_NOW(a_push_pop_excl, q_ctrl.push, !q_ctrl.pop, "edge push and pop in one cycle")
  `MDBR_ASSERT_NOW(a_done_needs_tick, done, step_en, "frame result without a tick word")

endmodule

`default_nettype wire

>>> tb/mdb_nine_bit_edge_receiver_test.sv
// Self-checking testbench for mdb_nine_bit_edge_receiver: directed frames, then random
// frames, noise and register settings, checked against a frame decoder kept in the bench.
// Depends on mdbr_pkg and the receiver RTL only.
module mdb_nine_bit_edge_receiver_test;
  import mdbr_pkg::*;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_word_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  mdb_nine_bit_edge_receiver dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Decoder state, mirroring the receiver.
  cfg_regs_t   regs;
  logic [3:0]  rx_phase   = PHASE_IDLE;
  logic [31:0] frame_t0   = '0;
  logic        held_lvl   = 1'b0;
  logic [7:0]  byte_acc   = '0;
  logic        mode_acc   = 1'b0;
  logic [31:0] edge_t [EDGE_QUEUE_DEPTH];
  logic        edge_l [EDGE_QUEUE_DEPTH];
  int          edge_cnt   = 0;
  out_word_t   frames_due [$];

  int idle_pct       = 34;
  int useful_words   = 0;
  int words_sent     = 0;
  int frames_checked = 0;
  int settings_used  = 1;
  int bad_words      = 0;
  int reports        = 0;

  function automatic cfg_regs_t make_cfg(int sym, int settle, int dwin, int fwin, int inv);
    cfg_regs_t c;
    c.symbol_time     = 16'(sym);
    c.settle_margin   = 16'(settle);
    c.data_window     = 16'(dwin);
    c.frame_window    = 16'(fwin);
    c.invert_polarity = 1'(inv);
    return c;
  endfunction

  function automatic in_word_t line_edge(logic [31:0] t, logic lvl);
    in_word_t w;
    w.command    = CMD_EDGE;
    w.event_time = t;
    w.line_level = lvl;
    return w;
  endfunction

  function automatic in_word_t time_tick(logic [31:0] t);
    in_word_t w;
    w.command    = CMD_TICK;
    w.event_time = t;
    w.line_level = 1'($urandom());
    return w;
  endfunction

  function automatic void drop_head_edge();
    for (int i = 1; i < edge_cnt; i++) begin
      edge_t[i-1] = edge_t[i];
      edge_l[i-1] = edge_l[i];
    end
    edge_cnt--;
  endfunction

  // Applies one word to the decoder; returns 1 when the word changed its state.
  function automatic bit decode_word(in_word_t w);
    logic [3:0]  k;
    logic [31:0] rel;
    logic [63:0] due, elapsed, win, edge_off;
    bit          take;
    out_word_t   res;
    if (w.command == CMD_EDGE) begin
      if (edge_cnt >= EDGE_QUEUE_DEPTH) return 1'b0;
      edge_t[edge_cnt] = w.event_time;
      edge_l[edge_cnt] = w.line_level;
      edge_cnt++;
      return 1'b1;
    end
    k = rx_phase;
    if (k == PHASE_IDLE || k > PHASE_STOP) begin
      rx_phase = PHASE_IDLE;
      if (edge_cnt == 0) return 1'b0;
      frame_t0 = edge_t[0];
      held_lvl = edge_l[0];
      byte_acc = '0;
      mode_acc = 1'b0;
      rx_phase = PHASE_FIRST;
      drop_head_edge();
      return 1'b1;
    end
    due     = 64'(k) * 64'(regs.symbol_time);
    rel     = w.event_time - frame_t0;
    elapsed = {32'd0, rel};
    if (elapsed <= due + 64'(regs.settle_margin)) return 1'b0;
    win  = (k <= PHASE_LAST_DATA) ? 64'(regs.data_window) : 64'(regs.frame_window);
    take = 1'b0;
    if (edge_cnt > 0) begin
      rel      = edge_t[0] - frame_t0;
      edge_off = {32'd0, rel};
      take     = (edge_off + win > due) && (edge_off < due + win);
    end
    if (take) begin
      if (k <= PHASE_MODE) held_lvl = edge_l[0];
      drop_head_edge();
    end
    if (k <= PHASE_LAST_DATA) begin
      byte_acc[k-1] = held_lvl;
      rx_phase = k + 4'd1;
    end else if (k == PHASE_MODE) begin
      mode_acc = held_lvl;
      rx_phase = PHASE_STOP;
    end else begin
      res.rx_byte  = byte_acc ^ {8{regs.invert_polarity}};
      res.mode_bit = mode_acc ^ regs.invert_polarity;
      frames_due.push_back(res);
      rx_phase = PHASE_IDLE;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    out_stall <= (idle_pct != 0) && ($urandom_range(0, 99) < idle_pct);
  end

  always @(posedge clk) begin : check_results
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (frames_due.size() == 0) begin
        bad_words++;
        if (reports < 10) begin
          reports++;
          $display("unexpected word: byte %02h mode %0d", out_data.rx_byte, out_data.mode_bit);
        end
      end else begin
        want = frames_due.pop_front();
        frames_checked++;
        if (out_data.rx_byte !== want.rx_byte || out_data.mode_bit !== want.mode_bit) begin
          bad_words++;
          if (reports < 10) begin
            reports++;
            $display("mismatch: expected byte %02h mode %0d, got byte %02h mode %0d",
                     want.rx_byte, want.mode_bit, out_data.rx_byte, out_data.mode_bit);
          end
        end
      end
    end
  end

  task automatic send_word(in_word_t w);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    if (decode_word(w)) useful_words++;
  endtask

  task automatic drain_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frames_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic apply_config(cfg_regs_t c);
    write_reg(CFG_SYMBOL_TIME, c.symbol_time);
    write_reg(CFG_SETTLE_MARGIN, c.settle_margin);
    write_reg(CFG_DATA_WINDOW, c.data_window);
    write_reg(CFG_FRAME_WINDOW, c.frame_window);
    write_reg(CFG_INVERT, {15'd0, c.invert_polarity});
    cfg_we <= 1'b0;
    regs = c;
    settings_used++;
  endtask

  // Ticks far past every bit time until the receiver is idle with an empty queue.
  task automatic flush_receiver();
    while (edge_cnt != 0 || rx_phase != PHASE_IDLE)
      send_word(time_tick(frame_t0 + 32'h0100_0000));
  endtask

  task automatic send_noise(int count);
    logic [31:0] t;
    for (int i = 0; i < count; i++) begin
      t = $urandom_range(0, 1) ? $urandom()
                               : frame_t0 + $urandom_range(0, 12 * int'(regs.symbol_time) + 20);
      if ($urandom_range(0, 1)) send_word(line_edge(t, 1'($urandom())));
      else send_word(time_tick(t));
    end
  endtask

  // A frame with random content; edges where the line changes and at some other bits, mostly in the window.
  task automatic send_frame(int last_phase);
    logic [31:0] t0, bit_t, thr;
    logic [10:0] lv;
    int          win, jmax, j, r;
    t0 = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3000) : $urandom();
    lv = 11'($urandom());
    send_word(line_edge(t0, lv[0]));
    send_word(time_tick($urandom()));
    for (int k = 1; k <= last_phase; k++) begin
      win   = (k <= 8) ? int'(regs.data_window) : int'(regs.frame_window);
      bit_t = t0 + 32'(k) * 32'(regs.symbol_time);
      if (lv[k] != lv[k-1] || $urandom_range(0, 7) == 0) begin
        jmax = (win > 2000) ? 2000 : win - 1;
        r    = $urandom_range(0, 5);
        if (jmax < 0 || $urandom_range(0, 11) == 0) j = $urandom_range(0, 1) ? win + r : -(win + r);
        else j = int'($urandom_range(0, 2 * jmax)) - jmax;
        send_word(line_edge(bit_t + 32'(j), lv[k]));
      end
      thr = bit_t + 32'(regs.settle_margin);
      if ($urandom_range(0, 5) == 0)
        send_word(time_tick(thr - $urandom_range(0, int'(regs.settle_margin))));
      send_word(time_tick(thr + 1 + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 50) : 0)));
    end
  endtask

  task automatic run_phase(cfg_regs_t c, int quota);
    int start_count;
    int pick;
    drain_quiet();
    apply_config(c);
    start_count = useful_words;
    while (useful_words - start_count < quota) begin
      if ((edge_cnt != 0 || rx_phase != PHASE_IDLE) && $urandom_range(0, 3) != 0)
        flush_receiver();
      pick = $urandom_range(0, 9);
      if (pick == 0) send_noise($urandom_range(1, 8));
      else if (pick == 1) send_frame($urandom_range(0, 9));
      else send_frame(PHASE_STOP);
    end
  endtask

  // Default registers: an idle tick on an empty queue, a full queue that drops an edge,
  // a frame start just before the time wrap and an edge taken in the stop phase.
  task automatic test_default_frame();
    logic [31:0] t0;
    t0 = 32'hFFFF_FFF0;
    send_word(time_tick(32'h0000_0000));
    send_word(line_edge(t0, 1'b0));
    send_word(line_edge(t0 + 32'd106, 1'b1));
    send_word(line_edge(t0 + 32'd940, 1'b0));
    send_word(line_edge(t0 + 32'd1036, 1'b1));
    send_word(line_edge(32'hFFFF_FFFF, 1'b1));
    send_word(time_tick(32'hFFFF_FFFF));
    for (int k = 1; k <= 10; k++) send_word(time_tick(t0 + 32'(k) * 32'd104 + 32'd11));
  endtask

  // Zero symbol time with inversion; the last edge lies outside every window and stays queued.
  task automatic test_zero_symbol_time();
    logic [31:0] t0;
    t0 = 32'h8000_0000;
    drain_quiet();
    apply_config(make_cfg(0, 0, 2, 1, 1));
    send_word(line_edge(t0, 1'b1));
    send_word(line_edge(t0 + 32'd1, 1'b0));
    send_word(line_edge(t0 + 32'd5, 1'b1));
    send_word(time_tick(t0));
    for (int k = 1; k <= 10; k++) send_word(time_tick(t0 + 32'd1));
  endtask

  task automatic test_config_extremes();
    idle_pct = 0;
    run_phase(make_cfg(104, 10, 3, 5, 0), 140);
    idle_pct = 34;
    run_phase(make_cfg(1, 0, 1, 1, 1), 140);
    run_phase(make_cfg(65535, 65535, 65535, 65535, 0), 140);
    run_phase(make_cfg(50, 5, 0, 0, 1), 140);
    run_phase(make_cfg(0, 3, 1, 2, 0), 140);
  endtask

  task automatic test_random_configs();
    int sym;
    for (int p = 0; p < 5; p++) begin
      sym = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 65535) : $urandom_range(4, 400);
      run_phase(make_cfg(sym, $urandom_range(0, sym / 5), $urandom_range(0, sym / 8 + 2),
                         $urandom_range(0, sym / 6 + 2), $urandom_range(0, 1)), 140);
    end
  endtask

  initial begin
    regs = make_cfg(104, 10, 3, 5, 0);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_default_frame();
    test_zero_symbol_time();
    test_config_extremes();
    test_random_configs();
    flush_receiver();
    drain_quiet();
    $display("Sent %0d words, %0d of them changing receiver state, under %0d register settings.",
             words_sent, useful_words, settings_used);
    $display("Checked %0d frames against the bench decoder; %0d bad words.",
             frames_checked, bad_words);
    if (bad_words == 0 && frames_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(20 * 600000);
    $display("Timed out with %0d frames outstanding.", frames_due.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
